>>> hdl/skvt_pkg.sv
// Shared types, codes and helpers of the schema-checked key/value table.
`timescale 1ns / 1ps
`default_nettype none
package skvt_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned TYPE_W = 3;
  localparam int unsigned SIZE_W = 4;
  localparam int unsigned DATA_W = 64;

  localparam logic [OP_W-1:0] OP_SCHEMA_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_SCHEMA_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_SCHEMA_LOOKUP = 3'd2;
  localparam logic [OP_W-1:0] OP_SET           = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR         = 3'd4;
  localparam logic [OP_W-1:0] OP_GET           = 3'd5;

  localparam logic [TYPE_W-1:0] TYPE_INT    = 3'd0;
  localparam logic [TYPE_W-1:0] TYPE_UINT   = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_FLOAT  = 3'd2;
  localparam logic [TYPE_W-1:0] TYPE_STRING = 3'd3;
  localparam logic [TYPE_W-1:0] TYPE_BYTES  = 3'd4;

  typedef struct packed {
    logic hit;
    logic free;
    logic match;
  } skvt_scan_t;

  function automatic logic [DATA_W-1:0] byte_mask(input logic [SIZE_W-1:0] n);
    logic [DATA_W-1:0] m;
    for (int b = 0; b < DATA_W / 8; b++) begin
      m[b*8 +: 8] = (SIZE_W'(b) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

  function automatic logic size_ok(input logic [TYPE_W-1:0] typ,
                                   input logic [SIZE_W-1:0] limit,
                                   input logic [SIZE_W-1:0] len);
    logic ok;
    case (typ)
      TYPE_INT, TYPE_UINT, TYPE_FLOAT: ok = (len == limit);
      TYPE_STRING, TYPE_BYTES:         ok = (len <= limit);
      default:                         ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage
`default_nettype wire

>>> hdl/skvt_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module skvt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> hdl/skvt_scan.sv
// Shared key compare unit: tracks first matching and first empty slot of a scan.
`timescale 1ns / 1ps
`default_nettype none
module skvt_scan
  import skvt_pkg::*;
#(
  parameter int unsigned IDX_W  = 5,
  parameter int unsigned INFO_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              sample_i,
  input  wire logic [KEY_W-1:0]  key_i,
  input  wire logic [KEY_W-1:0]  rd_key_i,
  input  wire logic              rd_valid_i,
  input  wire logic [IDX_W-1:0]  rd_idx_i,
  input  wire logic [INFO_W-1:0] rd_info_i,
  output skvt_scan_t             flags_o,
  output logic      [IDX_W-1:0]  hit_idx_o,
  output logic      [IDX_W-1:0]  free_idx_o,
  output logic      [INFO_W-1:0] hit_info_o
);

  logic              match;
  logic              empty;
  logic              hit_q;
  logic              free_q;
  logic [IDX_W-1:0]  hit_idx_q;
  logic [IDX_W-1:0]  free_idx_q;
  logic [INFO_W-1:0] hit_info_q;

  assign match = sample_i && rd_valid_i && (rd_key_i == key_i);
  assign empty = sample_i && !rd_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (start_i) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else begin
      if (match) begin
        hit_q <= 1'b1;
      end
      if (empty) begin
        free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (match && !hit_q) begin
      hit_idx_q  <= rd_idx_i;
      hit_info_q <= rd_info_i;
    end
    if (empty && !free_q) begin
      free_idx_q <= rd_idx_i;
    end
  end

  assign flags_o    = '{hit: hit_q, free: free_q, match: match};
  assign hit_idx_o  = hit_idx_q;
  assign free_idx_o = free_idx_q;
  assign hit_info_o = hit_info_q;

endmodule
`default_nettype wire

>>> hdl/schema_checked_key_value_table_unit.sv
// Top level of the schema-checked key/value table: sequencer, tables, result register.
//
// Input channel: in_valid_i/in_ready_o carry one command word (op, key, type,
// size, data). Output channel: out_valid_o/out_ready_i carry one result word per
// command. in_ready_o is high only while the sequencer is idle; one command is
// worked on at a time.
// Each command walks a table one slot per cycle through the shared key compare
// unit, with registered RAM reads; the scan covers every slot of its table:
//   schema add, remove, lookup : the schema table
//   clear, get                 : the value table
//   set                        : the schema table, then the value table on a fitting schema
//   zero key, bad op or size   : no scan
// The sequencer returns to idle, ready for the next command, as the result enters the output register.
// A new command is accepted while a result still waits in the output register;
// if the receiver stalls, the finished command holds in its done state until
// the output register frees.
// Reset clears the slot valid bits of both tables at once, so both tables read
// empty right after reset; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module schema_checked_key_value_table_unit
  import skvt_pkg::*;
#(
  parameter int unsigned SCHEMA_ENTRIES  = 16,
  parameter int unsigned VALUE_ENTRIES   = 32,
  parameter int unsigned MAX_VALUE_BYTES = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [OP_W-1:0]   op_i,
  input  wire logic [KEY_W-1:0]  key_i,
  input  wire logic [TYPE_W-1:0] value_type_i,
  input  wire logic [SIZE_W-1:0] value_size_i,
  input  wire logic [DATA_W-1:0] value_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   status_o,
  output logic                   found_o,
  output logic      [TYPE_W-1:0] found_type_o,
  output logic      [SIZE_W-1:0] found_size_o,
  output logic      [DATA_W-1:0] found_data_o
);

  localparam int unsigned SAW    = (SCHEMA_ENTRIES > 1) ? $clog2(SCHEMA_ENTRIES) : 1;
  localparam int unsigned VAW    = (VALUE_ENTRIES > 1) ? $clog2(VALUE_ENTRIES) : 1;
  localparam int unsigned CW     = (SAW > VAW) ? SAW : VAW;
  localparam int unsigned SCH_W  = KEY_W + TYPE_W + SIZE_W;
  localparam int unsigned VK_W   = KEY_W + SIZE_W;
  localparam int unsigned INFO_W = TYPE_W + SIZE_W + DATA_W;

  localparam logic [CW-1:0]     S_LAST   = CW'(SCHEMA_ENTRIES - 1);
  localparam logic [CW-1:0]     V_LAST   = CW'(VALUE_ENTRIES - 1);
  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_VALUE_BYTES);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic                tab_q, tab_d;
  logic [CW-1:0]       addr_q, addr_d;
  logic                rd_vld_q;
  logic [CW-1:0]       rd_idx_q;
  logic                svrd_q, vvrd_q;
  logic [SCHEMA_ENTRIES-1:0] sval_q;
  logic [VALUE_ENTRIES-1:0]  vval_q;

  logic [OP_W-1:0]     op_q;
  logic [KEY_W-1:0]    key_q;
  logic [TYPE_W-1:0]   vt_q;
  logic [SIZE_W-1:0]   vs_q;
  logic [DATA_W-1:0]   vd_q;

  logic                res_load;
  logic                res_status_d, res_status_q;
  logic                res_found_d, res_found_q;
  logic [TYPE_W-1:0]   res_type_d, res_type_q;
  logic [SIZE_W-1:0]   res_size_d, res_size_q;
  logic [DATA_W-1:0]   res_data_d, res_data_q;

  logic                out_load;
  logic                out_valid_q;
  logic                out_status_q, out_found_q;
  logic [TYPE_W-1:0]   out_type_q;
  logic [SIZE_W-1:0]   out_size_q;
  logic [DATA_W-1:0]   out_data_q;

  logic                accept;
  logic                early_err;
  logic                scan_start;
  logic                s_we, v_we, s_clr, v_clr;
  logic [SCH_W-1:0]    s_rdata;
  logic [VK_W-1:0]     vk_rdata;
  logic [DATA_W-1:0]   vd_rdata;
  logic [KEY_W-1:0]    rd_key;
  logic                rd_valid;
  logic [INFO_W-1:0]   rd_info;
  skvt_scan_t          flags;
  logic [CW-1:0]       hit_idx, free_idx, v_slot;
  logic [INFO_W-1:0]   hit_info;
  logic [TYPE_W-1:0]   h_type;
  logic [SIZE_W-1:0]   h_size;
  logic [DATA_W-1:0]   h_data;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  skvt_ram #(.WIDTH(SCH_W), .DEPTH(SCHEMA_ENTRIES)) u_schema_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (free_idx[SAW-1:0]),
    .wdata_i ({key_q, vt_q, vs_q}),
    .raddr_i (addr_q[SAW-1:0]),
    .rdata_o (s_rdata)
  );

  skvt_ram #(.WIDTH(VK_W), .DEPTH(VALUE_ENTRIES)) u_vkey_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_slot[VAW-1:0]),
    .wdata_i ({key_q, vs_q}),
    .raddr_i (addr_q[VAW-1:0]),
    .rdata_o (vk_rdata)
  );

  skvt_ram #(.WIDTH(DATA_W), .DEPTH(VALUE_ENTRIES)) u_vdata_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_slot[VAW-1:0]),
    .wdata_i (vd_q & byte_mask(vs_q)),
    .raddr_i (addr_q[VAW-1:0]),
    .rdata_o (vd_rdata)
  );

  always_comb begin
    if (tab_q) begin
      rd_key   = vk_rdata[VK_W-1 -: KEY_W];
      rd_valid = vvrd_q;
      rd_info  = {{TYPE_W{1'b0}}, vk_rdata[SIZE_W-1:0], vd_rdata};
    end else begin
      rd_key   = s_rdata[SCH_W-1 -: KEY_W];
      rd_valid = svrd_q;
      rd_info  = {s_rdata[SIZE_W +: TYPE_W], s_rdata[SIZE_W-1:0], {DATA_W{1'b0}}};
    end
  end

  skvt_scan #(.IDX_W(CW), .INFO_W(INFO_W)) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scan_start),
    .sample_i   (rd_vld_q),
    .key_i      (key_q),
    .rd_key_i   (rd_key),
    .rd_valid_i (rd_valid),
    .rd_idx_i   (rd_idx_q),
    .rd_info_i  (rd_info),
    .flags_o    (flags),
    .hit_idx_o  (hit_idx),
    .free_idx_o (free_idx),
    .hit_info_o (hit_info)
  );

  assign h_type = hit_info[INFO_W-1 -: TYPE_W];
  assign h_size = hit_info[DATA_W +: SIZE_W];
  assign h_data = hit_info[DATA_W-1:0];
  assign v_slot = flags.hit ? hit_idx : free_idx;

  assign s_clr = flags.match && !tab_q && (op_q == OP_SCHEMA_REMOVE);
  assign v_clr = flags.match && tab_q && (op_q == OP_CLEAR);

  assign early_err = (key_i == '0) || (op_i > OP_GET) ||
                     ((op_i == OP_SCHEMA_ADD) &&
                      ((value_size_i == '0) || (value_size_i > MAX_SIZE)));

  always_comb begin
    state_d      = state_q;
    tab_d        = tab_q;
    addr_d       = addr_q;
    scan_start   = 1'b0;
    s_we         = 1'b0;
    v_we         = 1'b0;
    out_load     = 1'b0;
    res_load     = 1'b0;
    res_status_d = 1'b1;
    res_found_d  = 1'b0;
    res_type_d   = '0;
    res_size_d   = '0;
    res_data_d   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (early_err) begin
            res_load = 1'b1;
            state_d  = ST_DONE;
          end else begin
            tab_d      = (op_i == OP_CLEAR) || (op_i == OP_GET);
            addr_d     = '0;
            scan_start = 1'b1;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (addr_q == (tab_q ? V_LAST : S_LAST)) begin
          state_d = ST_DRAIN;
        end else begin
          addr_d = addr_q + CW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d  = ST_DONE;
        res_load = 1'b1;
        case (op_q)
          OP_SCHEMA_ADD: begin
            if (!flags.hit && flags.free) begin
              s_we         = 1'b1;
              res_status_d = 1'b0;
            end
          end
          OP_SCHEMA_REMOVE, OP_CLEAR: begin
            res_status_d = 1'b0;
          end
          OP_SCHEMA_LOOKUP: begin
            res_status_d = 1'b0;
            res_found_d  = flags.hit;
            res_type_d   = flags.hit ? h_type : '0;
            res_size_d   = flags.hit ? h_size : '0;
          end
          OP_SET: begin
            if (!tab_q) begin
              if (flags.hit && size_ok(h_type, h_size, vs_q)) begin
                res_load   = 1'b0;
                tab_d      = 1'b1;
                addr_d     = '0;
                scan_start = 1'b1;
                state_d    = ST_SCAN;
              end
            end else if (flags.hit || flags.free) begin
              v_we         = 1'b1;
              res_status_d = 1'b0;
            end
          end
          OP_GET: begin
            res_status_d = 1'b0;
            res_found_d  = flags.hit;
            res_size_d   = flags.hit ? h_size : '0;
            res_data_d   = flags.hit ? h_data : '0;
          end
          default: begin
            res_status_d = 1'b1;
          end
        endcase
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tab_q       <= 1'b0;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      sval_q      <= '0;
      vval_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      tab_q    <= tab_d;
      addr_q   <= addr_d;
      rd_vld_q <= (state_q == ST_SCAN);
      if (s_we) begin
        sval_q[free_idx[SAW-1:0]] <= 1'b1;
      end
      if (s_clr) begin
        sval_q[rd_idx_q[SAW-1:0]] <= 1'b0;
      end
      if (v_we) begin
        vval_q[v_slot[VAW-1:0]] <= 1'b1;
      end
      if (v_clr) begin
        vval_q[rd_idx_q[VAW-1:0]] <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= addr_q;
    svrd_q   <= sval_q[addr_q[SAW-1:0]];
    vvrd_q   <= vval_q[addr_q[VAW-1:0]];
    if (accept) begin
      op_q  <= op_i;
      key_q <= key_i;
      vt_q  <= value_type_i;
      vs_q  <= value_size_i;
      vd_q  <= value_data_i;
    end
    if (res_load) begin
      res_status_q <= res_status_d;
      res_found_q  <= res_found_d;
      res_type_q   <= res_type_d;
      res_size_q   <= res_size_d;
      res_data_q   <= res_data_d;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_type_q   <= res_type_q;
      out_size_q   <= res_size_q;
      out_data_q   <= res_data_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign found_o      = out_found_q;
  assign found_type_o = out_type_q;
  assign found_size_o = out_size_q;
  assign found_data_o = out_data_q;

endmodule
`default_nettype wire

>>> hdl/skvt_checker.sv
// Port-level assertions for the key/value table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module skvt_checker
  import skvt_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic              status_o,
  input wire logic              found_o,
  input wire logic [TYPE_W-1:0] found_type_o,
  input wire logic [SIZE_W-1:0] found_size_o,
  input wire logic [DATA_W-1:0] found_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(status_o) && $stable(found_o) && $stable(found_type_o) &&
      $stable(found_size_o) && $stable(found_data_o))
    else $error("stalled result word changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after a command word was taken");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> !status_o)
    else $error("found reported with error status");

  a_fields_need_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((found_type_o != '0) || (found_size_o != '0) ||
                    (found_data_o != '0)) |-> found_o)
    else $error("found fields set without a hit");

endmodule

bind schema_checked_key_value_table_unit skvt_checker u_skvt_checker (.*);
`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the schema-checked key/value table unit.
`timescale 1ns / 1ps
module tb;
  import skvt_pkg::*;

  localparam int SCHEMA_ENTRIES = 16;
  localparam int VALUE_ENTRIES  = 32;
  localparam int MAX_BYTES      = 8;

  localparam logic [OP_W-1:0]   OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0]   OP_RSVD_7 = 3'd7;
  localparam logic [TYPE_W-1:0] TYPE_RSVD = 3'd7;
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  localparam int POOL_SIZE    = 24;
  localparam int RANDOM_ITEMS = 600;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 3000;
  localparam int END_CYCLES   = 100;

  typedef struct packed {
    logic              status;
    logic              found;
    logic [TYPE_W-1:0] ftype;
    logic [SIZE_W-1:0] fsize;
    logic [DATA_W-1:0] fdata;
  } result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [OP_W-1:0]   op_i;
  logic [KEY_W-1:0]  key_i;
  logic [TYPE_W-1:0] value_type_i;
  logic [SIZE_W-1:0] value_size_i;
  logic [DATA_W-1:0] value_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              status_o;
  logic              found_o;
  logic [TYPE_W-1:0] found_type_o;
  logic [SIZE_W-1:0] found_size_o;
  logic [DATA_W-1:0] found_data_o;

  // predicted table contents
  logic [KEY_W-1:0]  sch_key   [SCHEMA_ENTRIES] = '{default: '0};
  logic [TYPE_W-1:0] sch_type  [SCHEMA_ENTRIES] = '{default: '0};
  logic [SIZE_W-1:0] sch_limit [SCHEMA_ENTRIES] = '{default: '0};
  logic [KEY_W-1:0]  val_key   [VALUE_ENTRIES]  = '{default: '0};
  logic [SIZE_W-1:0] val_len   [VALUE_ENTRIES]  = '{default: '0};
  logic [DATA_W-1:0] val_word  [VALUE_ENTRIES]  = '{default: '0};

  result_t pending_results[$];
  int      err_count    = 0;
  int      burst_left   = 0;
  logic    hold_off_req = 1'b0;

  schema_checked_key_value_table_unit #(
    .SCHEMA_ENTRIES (SCHEMA_ENTRIES),
    .VALUE_ENTRIES  (VALUE_ENTRIES),
    .MAX_VALUE_BYTES(MAX_BYTES)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .key_i        (key_i),
    .value_type_i (value_type_i),
    .value_size_i (value_size_i),
    .value_data_i (value_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .found_o      (found_o),
    .found_type_o (found_type_o),
    .found_size_o (found_size_o),
    .found_data_o (found_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int schema_slot(input logic [KEY_W-1:0] key);
    for (int i = 0; i < SCHEMA_ENTRIES; i++) begin
      if (sch_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic int value_slot(input logic [KEY_W-1:0] key);
    for (int i = 0; i < VALUE_ENTRIES; i++) begin
      if (val_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic logic length_fits(input logic [KEY_W-1:0] key,
                                       input logic [SIZE_W-1:0] len);
    int s;
    s = schema_slot(key);
    if (s < 0) return 1'b0;
    case (sch_type[s])
      TYPE_INT, TYPE_UINT, TYPE_FLOAT: return len == sch_limit[s];
      TYPE_STRING, TYPE_BYTES:         return len <= sch_limit[s];
      default:                         return 1'b0;
    endcase
  endfunction

  // a length the schema accepts, or a random one when there is none
  function automatic logic [SIZE_W-1:0] legal_length(input logic [KEY_W-1:0] key);
    int s;
    s = schema_slot(key);
    if (s < 0) return SIZE_W'($urandom);
    case (sch_type[s])
      TYPE_INT, TYPE_UINT, TYPE_FLOAT: return sch_limit[s];
      TYPE_STRING, TYPE_BYTES:         return SIZE_W'($urandom_range(0, sch_limit[s]));
      default:                         return SIZE_W'($urandom);
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    k = $urandom;
    if (k == '0) k = 32'h8000_0001;
    return k;
  endfunction

  // updates the predicted tables and returns the expected result word
  function automatic result_t table_predict(input logic [OP_W-1:0]   op,
                                            input logic [KEY_W-1:0]  key,
                                            input logic [TYPE_W-1:0] vt,
                                            input logic [SIZE_W-1:0] vs,
                                            input logic [DATA_W-1:0] vd);
    result_t r;
    int      slot;
    r = '0;
    r.status = ST_ERR;
    if (key != '0) begin
      case (op)
        OP_SCHEMA_ADD: begin
          if (schema_slot(key) < 0 && vs != '0 && vs <= MAX_BYTES) begin
            slot = schema_slot('0);
            if (slot >= 0) begin
              sch_key[slot]   = key;
              sch_type[slot]  = vt;
              sch_limit[slot] = vs;
              r.status = ST_OK;
            end
          end
        end
        OP_SCHEMA_REMOVE: begin
          for (int i = 0; i < SCHEMA_ENTRIES; i++) begin
            if (sch_key[i] == key) begin
              sch_key[i]   = '0;
              sch_type[i]  = '0;
              sch_limit[i] = '0;
            end
          end
          r.status = ST_OK;
        end
        OP_SCHEMA_LOOKUP: begin
          r.status = ST_OK;
          slot = schema_slot(key);
          if (slot >= 0) begin
            r.found = 1'b1;
            r.ftype = sch_type[slot];
            r.fsize = sch_limit[slot];
          end
        end
        OP_SET: begin
          if (length_fits(key, vs)) begin
            slot = value_slot(key);
            if (slot < 0) slot = value_slot('0);
            if (slot >= 0) begin
              val_key[slot] = key;
              val_len[slot] = vs;
              if (vs >= MAX_BYTES) val_word[slot] = vd;
              else val_word[slot] = vd & ((64'd1 << (8 * int'(vs))) - 64'd1);
              r.status = ST_OK;
            end
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < VALUE_ENTRIES; i++) begin
            if (val_key[i] == key) begin
              val_key[i]  = '0;
              val_len[i]  = '0;
              val_word[i] = '0;
            end
          end
          r.status = ST_OK;
        end
        OP_GET: begin
          r.status = ST_OK;
          slot = value_slot(key);
          if (slot >= 0) begin
            r.found = 1'b1;
            r.fsize = val_len[slot];
            r.fdata = val_word[slot];
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // offer one command word, wait for it to be taken, then maybe pause
  task automatic send_word(input logic [OP_W-1:0]   op,
                           input logic [KEY_W-1:0]  key,
                           input logic [TYPE_W-1:0] vt,
                           input logic [SIZE_W-1:0] vs,
                           input logic [DATA_W-1:0] vd);
    int gap;
    in_valid_i   <= 1'b1;
    op_i         <= op;
    key_i        <= key;
    value_type_i <= vt;
    value_size_i <= vs;
    value_data_i <= vd;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    pending_results.push_back(table_predict(op, key, vt, vs, vd));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic test_directed();
    logic [DATA_W-1:0] d;
    d = {$urandom, $urandom};
    // zero key on every operation, unknown opcodes
    send_word(OP_GET, '0, TYPE_INT, 4'd8, d);
    send_word(OP_SCHEMA_LOOKUP, '0, TYPE_INT, 4'd8, d);
    send_word(OP_SCHEMA_ADD, '0, TYPE_INT, 4'd4, d);
    send_word(OP_SCHEMA_REMOVE, '0, TYPE_INT, 4'd4, d);
    send_word(OP_CLEAR, '0, TYPE_INT, 4'd4, d);
    send_word(OP_SET, '0, TYPE_INT, 4'd4, d);
    send_word(OP_RSVD_6, 32'h1, TYPE_INT, 4'd0, '0);
    send_word(OP_RSVD_7, '1, TYPE_RSVD, 4'hf, '1);
    // schema checks
    send_word(OP_SET, 32'h1, TYPE_INT, 4'd4, d);
    send_word(OP_SCHEMA_ADD, 32'h1, TYPE_INT, 4'd0, d);
    send_word(OP_SCHEMA_ADD, 32'h1, TYPE_INT, 4'd9, d);
    send_word(OP_SCHEMA_ADD, 32'h1, TYPE_INT, 4'd4, d);
    send_word(OP_SCHEMA_ADD, 32'h1, TYPE_STRING, 4'd8, d);
    send_word(OP_SCHEMA_ADD, '1, TYPE_STRING, 4'd8, d);
    send_word(OP_SCHEMA_ADD, 32'h2, TYPE_RSVD, 4'd8, d);
    send_word(OP_SCHEMA_ADD, 32'h3, TYPE_FLOAT, 4'd1, d);
    send_word(OP_SCHEMA_ADD, 32'h4, TYPE_BYTES, 4'hf, d);
    send_word(OP_SCHEMA_LOOKUP, 32'h2, TYPE_INT, 4'd0, d);
    send_word(OP_SCHEMA_LOOKUP, 32'h5, TYPE_INT, 4'd0, d);
    // sets against the schema
    send_word(OP_SET, 32'h1, TYPE_INT, 4'd3, '1);
    send_word(OP_SET, 32'h1, TYPE_INT, 4'd4, '1);
    send_word(OP_GET, 32'h1, TYPE_INT, 4'd0, '0);
    send_word(OP_SET, '1, TYPE_INT, 4'd0, d);
    send_word(OP_SET, '1, TYPE_INT, 4'd8, {$urandom, $urandom});
    send_word(OP_SET, '1, TYPE_INT, 4'd9, d);
    send_word(OP_SET, 32'h2, TYPE_INT, 4'd8, d);
    send_word(OP_SET, 32'h3, TYPE_INT, 4'd1, '1);
    send_word(OP_GET, '1, TYPE_INT, 4'd0, '0);
    // clear, and schema removal leaving the stored value
    send_word(OP_CLEAR, 32'h1, TYPE_INT, 4'd0, '0);
    send_word(OP_GET, 32'h1, TYPE_INT, 4'd0, '0);
    send_word(OP_SCHEMA_REMOVE, '1, TYPE_INT, 4'd0, '0);
    send_word(OP_GET, '1, TYPE_INT, 4'd0, '0);
    send_word(OP_SCHEMA_REMOVE, 32'h5, TYPE_INT, 4'd0, '0);
  endtask

  // fill both tables past capacity, overwrite in a full table, then empty them
  task automatic test_table_full();
    logic [KEY_W-1:0] cur [SCHEMA_ENTRIES+1];
    logic [KEY_W-1:0] old [SCHEMA_ENTRIES+1];
    logic [KEY_W-1:0] k;
    for (int i = 0; i < SCHEMA_ENTRIES; i++) begin
      k = sch_key[i];
      if (k != '0) send_word(OP_SCHEMA_REMOVE, k, TYPE_INT, 4'd0, '0);
    end
    for (int i = 0; i <= SCHEMA_ENTRIES; i++) old[i] = '0;
    repeat (3) begin
      for (int i = 0; i <= SCHEMA_ENTRIES; i++) begin
        if (old[i] != '0) send_word(OP_SCHEMA_REMOVE, old[i], TYPE_INT, 4'd0, '0);
      end
      for (int i = 0; i <= SCHEMA_ENTRIES; i++) begin
        cur[i] = fresh_key();
        send_word(OP_SCHEMA_ADD, cur[i], TYPE_W'($urandom_range(0, 4)),
                  SIZE_W'($urandom_range(1, MAX_BYTES)), '0);
      end
      for (int i = 0; i <= SCHEMA_ENTRIES; i++) begin
        send_word(OP_SET, cur[i], TYPE_INT, legal_length(cur[i]), {$urandom, $urandom});
      end
      send_word(OP_SET, cur[0], TYPE_INT, legal_length(cur[0]), {$urandom, $urandom});
      send_word(OP_GET, cur[0], TYPE_INT, 4'd0, '0);
      old = cur;
    end
    for (int i = 0; i < VALUE_ENTRIES; i++) begin
      k = val_key[i];
      if (k != '0) send_word(OP_CLEAR, k, TYPE_INT, 4'd0, '0);
    end
    for (int i = 0; i < SCHEMA_ENTRIES; i++) begin
      k = sch_key[i];
      if (k != '0) send_word(OP_SCHEMA_REMOVE, k, TYPE_INT, 4'd0, '0);
    end
  endtask

  task automatic test_random_traffic();
    logic [KEY_W-1:0]  pool [POOL_SIZE];
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;
    logic [TYPE_W-1:0] vt;
    logic [SIZE_W-1:0] vs;
    logic [DATA_W-1:0] vd;
    int                pick;
    pool[0] = 32'h1;
    pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) pool[i] = fresh_key();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      key  = pool[$urandom_range(0, POOL_SIZE - 1)];
      if ($urandom_range(0, 99) == 0) key = $urandom;
      vt = ($urandom_range(0, 6) == 0) ? TYPE_W'($urandom_range(5, 7)) :
                                         TYPE_W'($urandom_range(0, 4));
      vs = ($urandom_range(0, 6) == 0) ? SIZE_W'($urandom) :
                                         SIZE_W'($urandom_range(1, MAX_BYTES));
      vd = {$urandom, $urandom};
      if (pick < 4) begin
        op  = OP_W'($urandom);
        key = '0;
      end else if (pick < 6) begin
        op = $urandom_range(0, 1) ? OP_RSVD_6 : OP_RSVD_7;
      end else if (pick < 20) begin
        op = OP_SCHEMA_ADD;
      end else if (pick < 25) begin
        op = OP_SCHEMA_REMOVE;
      end else if (pick < 32) begin
        op = OP_SCHEMA_LOOKUP;
      end else if (pick < 62) begin
        op = OP_SET;
        if ($urandom_range(0, 4) != 0) vs = legal_length(key);
      end else if (pick < 70) begin
        op = OP_CLEAR;
      end else begin
        op = OP_GET;
      end
      if (n == HOLD_AT) hold_off_req = 1'b1;
      send_word(op, key, vt, vs, vd);
    end
  endtask

  // receiver: phases of always-ready, a fixed pattern, or random stalls
  initial begin
    int          mode;
    int          phase_left;
    int          hold_left;
    int          tick;
    logic [31:0] pattern;
    mode        = 0;
    phase_left  = 0;
    hold_left   = 0;
    tick        = 0;
    pattern     = '1;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 2);
        phase_left = $urandom_range(16, 160);
        pattern    = $urandom | 32'h1;
      end
      phase_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (mode == 0) begin
        out_ready_i <= 1'b1;
      end else if (mode == 1) begin
        out_ready_i <= pattern[tick % 32];
      end else begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(negedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with no command pending");
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0h, got %0h", want.status, status_o);
          err_count++;
        end
        if (found_o !== want.found) begin
          $error("found: expected %0h, got %0h", want.found, found_o);
          err_count++;
        end
        if (found_type_o !== want.ftype) begin
          $error("found_type: expected %0h, got %0h", want.ftype, found_type_o);
          err_count++;
        end
        if (found_size_o !== want.fsize) begin
          $error("found_size: expected %0h, got %0h", want.fsize, found_size_o);
          err_count++;
        end
        if (found_data_o !== want.fdata) begin
          $error("found_data: expected %0h, got %0h", want.fdata, found_data_o);
          err_count++;
        end
      end
    end
  end

  // watchdog: ends the run when no word moves on either side for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(negedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    in_valid_i   = 1'b0;
    op_i         = '0;
    key_i        = '0;
    value_type_i = '0;
    value_size_i = '0;
    value_data_i = '0;
    rst_ni       = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_random_traffic();
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (END_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
